[rtl/rvdec_pkg.sv]
// rvdec_pkg: instruction numbers, opcodes and the decoded result type
// for the rv32i instruction decoder; no dependencies
package rvdec_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CodeW = 6;
  localparam int unsigned RegW  = 5;

  // dense instruction number, fixed mnemonic order
  typedef enum logic [CodeW-1:0] {
    INST_LUI    = 6'd0,
    INST_AUIPC  = 6'd1,
    INST_JAL    = 6'd2,
    INST_JALR   = 6'd3,
    INST_BEQ    = 6'd4,
    INST_BNE    = 6'd5,
    INST_BLT    = 6'd6,
    INST_BGE    = 6'd7,
    INST_BLTU   = 6'd8,
    INST_BGEU   = 6'd9,
    INST_LB     = 6'd10,
    INST_LH     = 6'd11,
    INST_LW     = 6'd12,
    INST_LBU    = 6'd13,
    INST_LHU    = 6'd14,
    INST_SB     = 6'd15,
    INST_SH     = 6'd16,
    INST_SW     = 6'd17,
    INST_ADDI   = 6'd18,
    INST_SLTI   = 6'd19,
    INST_SLTIU  = 6'd20,
    INST_XORI   = 6'd21,
    INST_ORI    = 6'd22,
    INST_ANDI   = 6'd23,
    INST_SLLI   = 6'd24,
    INST_SRLI   = 6'd25,
    INST_SRAI   = 6'd26,
    INST_ADD    = 6'd27,
    INST_SUB    = 6'd28,
    INST_SLL    = 6'd29,
    INST_SLT    = 6'd30,
    INST_SLTU   = 6'd31,
    INST_XOR    = 6'd32,
    INST_SRL    = 6'd33,
    INST_SRA    = 6'd34,
    INST_OR     = 6'd35,
    INST_AND    = 6'd36,
    INST_ECALL  = 6'd37,
    INST_EBREAK = 6'd38,
    INST_NONE   = 6'd39
  } inst_e;

  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6F;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcAluI   = 7'h13;
  localparam logic [6:0] OpcAluR   = 7'h33;
  localparam logic [6:0] OpcSystem = 7'h73;

  typedef struct packed {
    inst_e              code;
    logic [RegW-1:0]    rd;
    logic [RegW-1:0]    rs1;
    logic [RegW-1:0]    rs2;
    logic [WordW-1:0]   imm;
  } dec_t;

endpackage

[rtl/rvdec_decode.sv]
// rvdec_decode: combinational decode of one instruction word into
// instruction number, register fields and immediate; uses rvdec_pkg
module rvdec_decode (
  input  logic [rvdec_pkg::WordW-1:0] instr_word_i,
  output rvdec_pkg::dec_t             dec_o
);

  logic [6:0]                 opc;
  logic [2:0]                 f3;
  logic                       alt;
  logic [rvdec_pkg::WordW-1:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;
  rvdec_pkg::inst_e           code;
  logic [rvdec_pkg::WordW-1:0] imm;

  assign opc = instr_word_i[6:0];
  assign f3  = instr_word_i[14:12];
  assign alt = instr_word_i[30];

  assign imm_i  = {{20{instr_word_i[31]}}, instr_word_i[31:20]};
  assign imm_s  = {{20{instr_word_i[31]}}, instr_word_i[31:25], instr_word_i[11:7]};
  assign imm_b  = {{20{instr_word_i[31]}}, instr_word_i[7], instr_word_i[30:25],
                   instr_word_i[11:8], 1'b0};
  assign imm_j  = {{12{instr_word_i[31]}}, instr_word_i[19:12], instr_word_i[20],
                   instr_word_i[30:21], 1'b0};
  assign imm_u  = {12'd0, instr_word_i[31:12]};
  assign imm_sh = {27'd0, instr_word_i[24:20]};

  always_comb begin
    code = rvdec_pkg::INST_NONE;
    imm  = '0;
    case (opc)
      rvdec_pkg::OpcLui: begin
        code = rvdec_pkg::INST_LUI;
        imm  = imm_u;
      end
      rvdec_pkg::OpcAuipc: begin
        code = rvdec_pkg::INST_AUIPC;
        imm  = imm_u;
      end
      rvdec_pkg::OpcJal: begin
        code = rvdec_pkg::INST_JAL;
        imm  = imm_j;
      end
      rvdec_pkg::OpcJalr: begin
        code = rvdec_pkg::INST_JALR;
        imm  = imm_i;
      end
      rvdec_pkg::OpcBranch: begin
        imm = imm_b;
        case (f3)
          3'd0:    code = rvdec_pkg::INST_BEQ;
          3'd1:    code = rvdec_pkg::INST_BNE;
          3'd4:    code = rvdec_pkg::INST_BLT;
          3'd5:    code = rvdec_pkg::INST_BGE;
          3'd6:    code = rvdec_pkg::INST_BLTU;
          3'd7:    code = rvdec_pkg::INST_BGEU;
          default: code = rvdec_pkg::INST_NONE;
        endcase
      end
      rvdec_pkg::OpcLoad: begin
        imm = imm_i;
        case (f3)
          3'd0:    code = rvdec_pkg::INST_LB;
          3'd1:    code = rvdec_pkg::INST_LH;
          3'd2:    code = rvdec_pkg::INST_LW;
          3'd4:    code = rvdec_pkg::INST_LBU;
          3'd5:    code = rvdec_pkg::INST_LHU;
          default: code = rvdec_pkg::INST_NONE;
        endcase
      end
      rvdec_pkg::OpcStore: begin
        imm = imm_s;
        case (f3)
          3'd0:    code = rvdec_pkg::INST_SB;
          3'd1:    code = rvdec_pkg::INST_SH;
          3'd2:    code = rvdec_pkg::INST_SW;
          default: code = rvdec_pkg::INST_NONE;
        endcase
      end
      rvdec_pkg::OpcAluI: begin
        imm = imm_i;
        case (f3)
          3'd0: code = rvdec_pkg::INST_ADDI;
          3'd1: begin
            code = rvdec_pkg::INST_SLLI;
            imm  = imm_sh;
          end
          3'd2: code = rvdec_pkg::INST_SLTI;
          3'd3: code = rvdec_pkg::INST_SLTIU;
          3'd4: code = rvdec_pkg::INST_XORI;
          3'd5: begin
            code = alt ? rvdec_pkg::INST_SRAI : rvdec_pkg::INST_SRLI;
            imm  = imm_sh;
          end
          3'd6: code = rvdec_pkg::INST_ORI;
          default: code = rvdec_pkg::INST_ANDI;
        endcase
      end
      rvdec_pkg::OpcAluR: begin
        case (f3)
          3'd0:    code = alt ? rvdec_pkg::INST_SUB : rvdec_pkg::INST_ADD;
          3'd1:    code = rvdec_pkg::INST_SLL;
          3'd2:    code = rvdec_pkg::INST_SLT;
          3'd3:    code = rvdec_pkg::INST_SLTU;
          3'd4:    code = rvdec_pkg::INST_XOR;
          3'd5:    code = alt ? rvdec_pkg::INST_SRA : rvdec_pkg::INST_SRL;
          3'd6:    code = rvdec_pkg::INST_OR;
          default: code = rvdec_pkg::INST_AND;
        endcase
      end
      rvdec_pkg::OpcSystem: begin
        // any nonzero rs2 field counts as ebreak
        code = (instr_word_i[24:20] != '0) ? rvdec_pkg::INST_EBREAK
                                           : rvdec_pkg::INST_ECALL;
      end
      default: begin
        code = rvdec_pkg::INST_NONE;
        imm  = '0;
      end
    endcase
    if (code == rvdec_pkg::INST_NONE) begin
      imm = '0;
    end
  end

  assign dec_o.code = code;
  assign dec_o.rd   = instr_word_i[11:7];
  assign dec_o.rs1  = instr_word_i[19:15];
  assign dec_o.rs2  = instr_word_i[24:20];
  assign dec_o.imm  = imm;

endmodule

[rtl/rv32i_instruction_decoder.sv]
// rv32i_instruction_decoder: top level, input word register, decode logic
// and result register; uses rvdec_pkg and rvdec_decode
//
// Decodes one RV32I instruction word per clock cycle unless out_ready_i stalls the output. A word
// taken on in_valid_i/in_ready_o is registered in word_q, decoded by short combinational logic
// and captured in the result register res_q, which drives the outputs; a new word can be taken
// every cycle while the output is not stalled.
// Throughput is one word per cycle, set by the two-register pipeline; in_ready_o drops only
// while both registers hold words and out_ready_i is low. inst_code_o numbers the instruction
// LUI..EBREAK as 0..38 and gives 39 for an unrecognised word (immediate 0). Register fields are
// always the raw bit fields; immediates follow the format (U gives bits 31:12 unshifted, shift
// immediates give the shift amount, R-type and environment calls give 0).
module rv32i_instruction_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rvdec_pkg::WordW-1:0]       instr_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rvdec_pkg::CodeW-1:0]       inst_code_o,
  output logic [rvdec_pkg::RegW-1:0]        dest_reg_o,
  output logic [rvdec_pkg::RegW-1:0]        src_reg_a_o,
  output logic [rvdec_pkg::RegW-1:0]        src_reg_b_o,
  output logic signed [rvdec_pkg::WordW-1:0] immediate_o
);

  logic                        word_valid_q;
  logic [rvdec_pkg::WordW-1:0] word_q;
  logic                        res_valid_q;
  rvdec_pkg::dec_t             res_q;
  rvdec_pkg::dec_t             dec_d;
  logic                        res_ready;
  logic                        word_ready;

  // result register can take a new word when empty or being drained
  assign res_ready  = !res_valid_q || out_ready_i;
  assign word_ready = !word_valid_q || res_ready;
  assign in_ready_o = word_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (word_ready) begin
      word_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_ready && in_valid_i) begin
      word_q <= instr_word_i;
    end
  end

  rvdec_decode u_decode (
    .instr_word_i (word_q),
    .dec_o        (dec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= word_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && word_valid_q) begin
      res_q <= dec_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign inst_code_o = res_q.code;
  assign dest_reg_o  = res_q.rd;
  assign src_reg_a_o = res_q.rs1;
  assign src_reg_b_o = res_q.rs2;
  assign immediate_o = res_q.imm;

endmodule

[rtl/rvdec_checker.sv]
// rvdec_checker: port-level assertions for the rv32i instruction decoder
// and the bind that attaches them; uses rvdec_pkg
module rvdec_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [rvdec_pkg::WordW-1:0]        instr_word_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [rvdec_pkg::CodeW-1:0]        inst_code_o,
  input logic [rvdec_pkg::RegW-1:0]         dest_reg_o,
  input logic [rvdec_pkg::RegW-1:0]         src_reg_a_o,
  input logic [rvdec_pkg::RegW-1:0]         src_reg_b_o,
  input logic signed [rvdec_pkg::WordW-1:0] immediate_o
);

  // a held result word keeps its code, immediate and destination register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inst_code_o)
      && $stable(immediate_o) && $stable(dest_reg_o))
    else $error("stalled result word changed");

  // unrecognised words, environment calls and add, sub, and, or carry no immediate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (inst_code_o == rvdec_pkg::INST_NONE
      || inst_code_o == rvdec_pkg::INST_ECALL || inst_code_o == rvdec_pkg::INST_EBREAK
      || inst_code_o == rvdec_pkg::INST_ADD || inst_code_o == rvdec_pkg::INST_SUB
      || inst_code_o == rvdec_pkg::INST_AND || inst_code_o == rvdec_pkg::INST_OR)
    |-> immediate_o == '0)
    else $error("immediate not zero for a format without one");

  // code never beyond the unrecognised marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inst_code_o <= rvdec_pkg::INST_NONE)
    else $error("instruction number out of range");

  // upper immediate and shift amount are zero-extended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (inst_code_o == rvdec_pkg::INST_LUI
      || inst_code_o == rvdec_pkg::INST_AUIPC) |-> immediate_o[31:20] == '0)
    else $error("upper immediate not zero-extended");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (inst_code_o == rvdec_pkg::INST_SLLI
      || inst_code_o == rvdec_pkg::INST_SRLI || inst_code_o == rvdec_pkg::INST_SRAI)
    |-> immediate_o == {27'd0, src_reg_b_o})
    else $error("shift immediate differs from shift amount");

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (.*);
